/* hw/rtl/gtg_pkg.sv */
// Shared constants, types, font table and pixel helper for the glyph renderer.
package gtg_pkg;

	localparam int CELL_COLUMNS = 6;
	localparam int GLYPH_ROWS   = 8;
	localparam int GLYPH_COUNT  = 96;
	localparam int FONT_COLS    = 5;
	localparam int FONT_BITS    = 7;

	localparam int NUM_PAIRS = (CELL_COLUMNS + 1) / 2;
	localparam int PAIR_W    = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;
	localparam int COL_W     = PAIR_W + 1;
	localparam int ROW_W     = $clog2(GLYPH_ROWS);
	localparam int GLYPH_W   = $clog2(GLYPH_COUNT);
	localparam int CODE_W    = 7;
	localparam int X_W       = 9;
	localparam int LIMIT_W   = 8;
	localparam int GREY_W    = 4;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd95;
	localparam logic [CODE_W-1:0]  CHAR_MASK   = 7'h7F;
	localparam logic [CODE_W-1:0]  FIRST_CODE  = 7'h20;
	localparam logic [X_W-1:0]     X_STEP      = 9'd2;

	typedef logic [FONT_BITS-1:0] font_col_t;
	typedef font_col_t [FONT_COLS-1:0] glyph_cols_t;

	typedef struct packed {
		logic               rd_en;
		logic [GLYPH_W-1:0] addr;
	} rom_req_t;

	// Column bitmaps, bit r of a column is glyph row r. Glyph 0 is the space.
	localparam font_col_t FONT_TABLE [GLYPH_COUNT][FONT_COLS] = '{
		'{7'h00,7'h00,7'h00,7'h00,7'h00}, '{7'h00,7'h00,7'h4f,7'h00,7'h00},
		'{7'h00,7'h07,7'h00,7'h07,7'h00}, '{7'h14,7'h7f,7'h14,7'h7f,7'h14},
		'{7'h24,7'h2a,7'h7f,7'h2a,7'h12}, '{7'h23,7'h13,7'h08,7'h64,7'h62},
		'{7'h36,7'h49,7'h55,7'h22,7'h50}, '{7'h00,7'h05,7'h03,7'h00,7'h00},
		'{7'h00,7'h1c,7'h22,7'h41,7'h00}, '{7'h00,7'h41,7'h22,7'h1c,7'h00},
		'{7'h14,7'h08,7'h3e,7'h08,7'h14}, '{7'h08,7'h08,7'h3e,7'h08,7'h08},
		'{7'h00,7'h50,7'h30,7'h00,7'h00}, '{7'h08,7'h08,7'h08,7'h08,7'h08},
		'{7'h00,7'h60,7'h60,7'h00,7'h00}, '{7'h20,7'h10,7'h08,7'h04,7'h02},
		'{7'h3e,7'h51,7'h49,7'h45,7'h3e}, '{7'h00,7'h42,7'h7f,7'h40,7'h00},
		'{7'h42,7'h61,7'h51,7'h49,7'h46}, '{7'h21,7'h41,7'h45,7'h4b,7'h31},
		'{7'h18,7'h14,7'h12,7'h7f,7'h10}, '{7'h27,7'h45,7'h45,7'h45,7'h39},
		'{7'h3c,7'h4a,7'h49,7'h49,7'h30}, '{7'h01,7'h71,7'h09,7'h05,7'h03},
		'{7'h36,7'h49,7'h49,7'h49,7'h36}, '{7'h06,7'h49,7'h49,7'h29,7'h1e},
		'{7'h00,7'h36,7'h36,7'h00,7'h00}, '{7'h00,7'h56,7'h36,7'h00,7'h00},
		'{7'h08,7'h14,7'h22,7'h41,7'h00}, '{7'h14,7'h14,7'h14,7'h14,7'h14},
		'{7'h00,7'h41,7'h22,7'h14,7'h08}, '{7'h02,7'h01,7'h51,7'h09,7'h06},
		'{7'h32,7'h49,7'h79,7'h41,7'h3e}, '{7'h7e,7'h11,7'h11,7'h11,7'h7e},
		'{7'h7f,7'h49,7'h49,7'h49,7'h36}, '{7'h3e,7'h41,7'h41,7'h41,7'h22},
		'{7'h7f,7'h41,7'h41,7'h22,7'h1c}, '{7'h7f,7'h49,7'h49,7'h49,7'h41},
		'{7'h7f,7'h09,7'h09,7'h09,7'h01}, '{7'h3e,7'h41,7'h49,7'h49,7'h7a},
		'{7'h7f,7'h08,7'h08,7'h08,7'h7f}, '{7'h00,7'h41,7'h7f,7'h41,7'h00},
		'{7'h20,7'h40,7'h41,7'h3f,7'h01}, '{7'h7f,7'h08,7'h14,7'h22,7'h41},
		'{7'h7f,7'h40,7'h40,7'h40,7'h40}, '{7'h7f,7'h02,7'h0c,7'h02,7'h7f},
		'{7'h7f,7'h04,7'h08,7'h10,7'h7f}, '{7'h3e,7'h41,7'h41,7'h41,7'h3e},
		'{7'h7f,7'h09,7'h09,7'h09,7'h06}, '{7'h3e,7'h41,7'h51,7'h21,7'h5e},
		'{7'h7f,7'h09,7'h19,7'h29,7'h46}, '{7'h46,7'h49,7'h49,7'h49,7'h31},
		'{7'h01,7'h01,7'h7f,7'h01,7'h01}, '{7'h3f,7'h40,7'h40,7'h40,7'h3f},
		'{7'h1f,7'h20,7'h40,7'h20,7'h1f}, '{7'h3f,7'h40,7'h38,7'h40,7'h3f},
		'{7'h63,7'h14,7'h08,7'h14,7'h63}, '{7'h07,7'h08,7'h70,7'h08,7'h07},
		'{7'h61,7'h51,7'h49,7'h45,7'h43}, '{7'h00,7'h7f,7'h41,7'h41,7'h00},
		'{7'h02,7'h04,7'h08,7'h10,7'h20}, '{7'h00,7'h41,7'h41,7'h7f,7'h00},
		'{7'h04,7'h02,7'h01,7'h02,7'h04}, '{7'h40,7'h40,7'h40,7'h40,7'h40},
		'{7'h00,7'h01,7'h02,7'h04,7'h00}, '{7'h20,7'h54,7'h54,7'h54,7'h78},
		'{7'h7f,7'h48,7'h44,7'h44,7'h38}, '{7'h38,7'h44,7'h44,7'h44,7'h20},
		'{7'h38,7'h44,7'h44,7'h48,7'h7f}, '{7'h38,7'h54,7'h54,7'h54,7'h18},
		'{7'h08,7'h7e,7'h09,7'h01,7'h02}, '{7'h0c,7'h52,7'h52,7'h52,7'h3e},
		'{7'h7f,7'h08,7'h04,7'h04,7'h78}, '{7'h00,7'h44,7'h7d,7'h40,7'h00},
		'{7'h20,7'h40,7'h44,7'h3d,7'h00}, '{7'h7f,7'h10,7'h28,7'h44,7'h00},
		'{7'h00,7'h41,7'h7f,7'h40,7'h00}, '{7'h7c,7'h04,7'h18,7'h04,7'h78},
		'{7'h7c,7'h08,7'h04,7'h04,7'h78}, '{7'h38,7'h44,7'h44,7'h44,7'h38},
		'{7'h7c,7'h14,7'h14,7'h14,7'h08}, '{7'h08,7'h14,7'h14,7'h18,7'h7c},
		'{7'h7c,7'h08,7'h04,7'h04,7'h08}, '{7'h48,7'h54,7'h54,7'h54,7'h20},
		'{7'h04,7'h3f,7'h44,7'h40,7'h20}, '{7'h3c,7'h40,7'h40,7'h20,7'h7c},
		'{7'h1c,7'h20,7'h40,7'h20,7'h1c}, '{7'h3c,7'h40,7'h30,7'h40,7'h3c},
		'{7'h44,7'h28,7'h10,7'h28,7'h44}, '{7'h0c,7'h50,7'h50,7'h50,7'h3c},
		'{7'h44,7'h64,7'h54,7'h4c,7'h44}, '{7'h00,7'h08,7'h36,7'h41,7'h00},
		'{7'h00,7'h00,7'h7f,7'h00,7'h00}, '{7'h00,7'h41,7'h36,7'h08,7'h00},
		'{7'h02,7'h01,7'h02,7'h04,7'h02}, '{7'h00,7'h00,7'h00,7'h00,7'h00}
	};

	// Columns past the font width and rows past the font height are dark.
	function automatic logic pixel_lit(glyph_cols_t cols, logic [COL_W-1:0] col,
			logic [ROW_W-1:0] row);
		logic lit;
		lit = 1'b0;
		for (int k = 0; k < FONT_COLS; k++) begin
			if (int'(col) == k && int'(row) < FONT_BITS) begin
				lit = cols[k][row];
			end
		end
		return lit;
	endfunction

endpackage

/* hw/rtl/gtg_ifs.sv */
// Channel interfaces: character input, pixel byte output, limit register write.
interface gtg_in_if;
	logic       valid;
	logic       ready;
	logic       new_string;
	logic [7:0] start_x;
	logic [7:0] char_code;
	logic [3:0] grey_level;

	modport source (output valid, output new_string, output start_x, output char_code,
		output grey_level, input ready);
	modport sink (input valid, input new_string, input start_x, input char_code,
		input grey_level, output ready);
endinterface

interface gtg_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_pair;
	logic       last_of_char;
	logic       hit_edge;

	modport source (output valid, output pixel_pair, output last_of_char, output hit_edge,
		input ready);
	modport sink (input valid, input pixel_pair, input last_of_char, input hit_edge,
		output ready);
endinterface

interface gtg_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/gtg_font_rom.sv */
// Synchronous font ROM: one glyph's five columns per read, ready in the cycle after the read.
module gtg_font_rom (
	input  logic                clk,
	input  gtg_pkg::rom_req_t   req,
	output gtg_pkg::glyph_cols_t cols_q
);

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			for (int k = 0; k < gtg_pkg::FONT_COLS; k++) begin
				cols_q[k] <= gtg_pkg::FONT_TABLE[req.addr][k];
			end
		end
	end

endmodule

/* hw/rtl/gtg_render.sv */
// Render sequencer: string position, glyph fetch, column-pair/row walk, output register.
module gtg_render (
	input  logic                  clk,
	input  logic                  arst_n,
	gtg_in_if.sink                glyph,
	gtg_out_if.source             pixel,
	input  logic [gtg_pkg::LIMIT_W-1:0] right_limit,
	output gtg_pkg::rom_req_t     rom_req,
	input  gtg_pkg::glyph_cols_t  rom_cols
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                    state_q;
	logic [gtg_pkg::X_W-1:0]       x_q;
	logic                          stopped_q;
	logic                          edge_q;
	logic [gtg_pkg::PAIR_W-1:0]    pair_q;
	logic [gtg_pkg::ROW_W-1:0]     row_q;
	logic [gtg_pkg::GREY_W-1:0]    grey_q;
	logic                          out_valid_q;
	logic [7:0]                    pixel_q;
	logic                          last_q;
	logic                          hit_q;

	logic                          accept;
	logic                          emit;
	logic [gtg_pkg::X_W-1:0]       x_start;
	logic                          stop_start;
	logic [gtg_pkg::X_W-1:0]       x_step;
	logic                          edge_next;
	logic [gtg_pkg::CODE_W-1:0]    code;
	logic                          row_last;
	logic                          pair_last;
	logic                          char_done;
	logic [gtg_pkg::COL_W-1:0]     col_even;
	logic [gtg_pkg::COL_W-1:0]     col_odd;
	logic [gtg_pkg::GREY_W-1:0]    hi;
	logic [gtg_pkg::GREY_W-1:0]    lo;

	assign glyph.ready = (state_q == ST_IDLE);
	assign accept      = glyph.valid & glyph.ready;
	assign x_start     = glyph.new_string ? {1'b0, glyph.start_x} : x_q;
	assign stop_start  = glyph.new_string ? 1'b0 : stopped_q;
	assign code        = glyph.char_code[gtg_pkg::CODE_W-1:0] & gtg_pkg::CHAR_MASK;

	// Control codes fall back to the blank glyph.
	assign rom_req.rd_en = accept & ~stop_start;
	assign rom_req.addr  = (code < gtg_pkg::FIRST_CODE) ? '0 :
		gtg_pkg::GLYPH_W'(code - gtg_pkg::FIRST_CODE);

	assign x_step    = x_q + gtg_pkg::X_STEP;
	assign edge_next = x_step > {1'b0, right_limit};

	assign emit      = (state_q == ST_EMIT) && (!out_valid_q || pixel.ready);
	assign row_last  = (row_q == gtg_pkg::ROW_W'(gtg_pkg::GLYPH_ROWS - 1));
	assign pair_last = (pair_q == gtg_pkg::PAIR_W'(gtg_pkg::NUM_PAIRS - 1));
	assign char_done = row_last && (edge_q || pair_last);

	assign col_even = {pair_q, 1'b0};
	assign col_odd  = {pair_q, 1'b1};
	assign hi = gtg_pkg::pixel_lit(rom_cols, col_even, row_q) ? grey_q : '0;
	assign lo = gtg_pkg::pixel_lit(rom_cols, col_odd, row_q) ? grey_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			x_q       <= '0;
			stopped_q <= 1'b0;
			edge_q    <= 1'b0;
			pair_q    <= '0;
			row_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						x_q       <= x_start;
						stopped_q <= stop_start;
						if (!stop_start) begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					// glyph columns land this cycle; first pair advances x
					x_q    <= x_step;
					edge_q <= edge_next;
					pair_q <= '0;
					row_q  <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit) begin
						if (char_done) begin
							stopped_q <= edge_q;
							state_q   <= ST_IDLE;
						end else if (row_last) begin
							pair_q <= pair_q + 1'b1;
							row_q  <= '0;
							x_q    <= x_step;
							edge_q <= edge_next;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			grey_q <= glyph.grey_level;
		end
		if (emit) begin
			pixel_q <= {hi, lo};
			last_q  <= char_done;
			hit_q   <= edge_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pixel.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign pixel.valid        = out_valid_q;
	assign pixel.pixel_pair   = pixel_q;
	assign pixel.last_of_char = last_q;
	assign pixel.hit_edge     = hit_q;

endmodule

/* hw/rtl/glyph_to_grayscale_renderer_unit.sv */
// Top level of the glyph renderer: limit register, font ROM and render sequencer.
//
//  channel  dir  handshake     payload
//  glyph    in   valid/ready   new_string, start_x, char_code, grey_level
//  pixel    out  valid/ready   pixel_pair, last_of_char, hit_edge
//  cfg      in   valid/ready   data -> right_limit
//
// A drawn character: IDLE accepts it and issues the font ROM read, LOAD takes the
// ROM's registered columns, and EMIT gives one byte per cycle while the pixel
// channel takes them, eight per column pair, three pairs for a full cell. The byte
// rate is set by the single output register. A stopped string yields no bytes.
// A stalled pixel channel holds the walk; reset gives x 0, not stopped, limit 95.
module glyph_to_grayscale_renderer_unit (
	input  logic       clk,
	input  logic       arst_n,
	gtg_in_if.sink     glyph,
	gtg_out_if.source  pixel,
	gtg_cfg_if.sink    cfg
);

	logic [gtg_pkg::LIMIT_W-1:0] limit_q;
	gtg_pkg::rom_req_t           rom_req;
	gtg_pkg::glyph_cols_t        rom_cols;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= gtg_pkg::LIMIT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			limit_q <= cfg.data;
		end
	end

	gtg_font_rom u_rom (
		.clk    (clk),
		.req    (rom_req),
		.cols_q (rom_cols)
	);

	gtg_render u_render (
		.clk         (clk),
		.arst_n      (arst_n),
		.glyph       (glyph),
		.pixel       (pixel),
		.right_limit (limit_q),
		.rom_req     (rom_req),
		.rom_cols    (rom_cols)
	);

endmodule

/* hw/rtl/gtg_checker.sv */
// Port-level checker for the glyph renderer and its bind to the top level.
module gtg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_pixel_pair,
	input logic       out_last,
	input logic       out_hit
);

	// a waiting byte holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pixel_pair) &&
			$stable(out_last) && $stable(out_hit))
		else $error("pixel transaction changed while stalled");

	// both nibbles carry the same grey when both are lit
	a_same_grey: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_pixel_pair[7:4] != 4'd0 && out_pixel_pair[3:0] != 4'd0
			|-> out_pixel_pair[7:4] == out_pixel_pair[3:0])
		else $error("pixel nibbles differ in grey");

	// no new character while the current one still has bytes to come
	a_no_early_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !(out_valid && !out_last))
		else $error("input ready while a character is unfinished");

	// bytes of one character follow without gaps when the sink keeps taking them
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid)
		else $error("gap inside a character");

endmodule

bind glyph_to_grayscale_renderer_unit gtg_checker u_gtg_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (glyph.ready),
	.out_valid      (pixel.valid),
	.out_ready      (pixel.ready),
	.out_pixel_pair (pixel.pixel_pair),
	.out_last       (pixel.last_of_char),
	.out_hit        (pixel.hit_edge)
);
